// File: hdl/rrs_pkg.sv
// package: payload types, colors, band limits and widths for the rounded-rect shader
package rrs_pkg;

	localparam int MAX_DIM = 1024;
	localparam int DIM_W = 11;
	localparam int RAD_W = 10;
	localparam int Q_W = 13;
	localparam int AX_W = 12;
	localparam int SQ_W = 2 * AX_W;
	localparam int SQRT_VAL_W = 40;
	localparam int DIST_W = 23;
	localparam int NUM_W = 9;
	localparam int T_W = 9;

	localparam logic signed [DIST_W-1:0] HALF_AA = 23'sd154;
	localparam logic signed [DIST_W-1:0] INNER_BORDER = 23'sd230;
	localparam logic signed [DIST_W-1:0] INNER_FRINGE = 23'sd538;
	localparam logic [16:0] AA_HALF_ROUND = 17'd153;
	localparam logic [15:0] RECIP_K = 16'd54649;
	localparam int RECIP_SH = 24;
	localparam logic [T_W-1:0] T_ONE = 9'd256;
	localparam logic [7:0] FAINT_ALPHA = 8'd8;

	localparam logic [7:0] FILL_A = 8'd180;
	localparam logic [7:0] FILL_R = 8'd20;
	localparam logic [7:0] FILL_G = 8'd20;
	localparam logic [7:0] FILL_B = 8'd28;
	localparam logic [7:0] BDR_A = 8'd210;
	localparam logic [7:0] BDR_R = 8'd100;
	localparam logic [7:0] BDR_G = 8'd110;
	localparam logic [7:0] BDR_B = 8'd140;

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	typedef enum logic [2:0] {
		BAND_NONE,
		BAND_OUTER,
		BAND_BORDER,
		BAND_INNER,
		BAND_FILL
	} band_t;

	typedef struct packed {
		logic [9:0] pixel_x;
		logic [9:0] pixel_y;
	} pix_t;

	typedef struct packed {
		logic [7:0] alpha_out;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} col_t;

	// per-item data carried alongside the square root
	typedef struct packed {
		logic kill;
		logic signed [Q_W-1:0] mq;
		logic [RAD_W-1:0] rad;
	} side_t;

	function automatic logic [7:0] blend(input logic [7:0] b, input logic [7:0] f,
		input logic [T_W-1:0] t);
		logic [17:0] acc;
		acc = 18'(b) * 18'(t) + 18'(f) * 18'(T_ONE - t) + 18'd128;
		return acc[15:8];
	endfunction

endpackage

// File: hdl/rrs_isqrt.sv
// pipelined integer square root, one result bit per stage, with sideband data
module rrs_isqrt #(
	parameter int VAL_W = rrs_pkg::SQRT_VAL_W,
	parameter int SB_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld,
	input  logic [VAL_W-1:0]     val,
	input  logic [SB_W-1:0]      sb,
	output logic                 root_vld,
	output logic [VAL_W/2-1:0]   root,
	output logic [SB_W-1:0]      root_sb
);

	localparam int N = VAL_W / 2;

	logic             vld_s [0:N];
	logic [VAL_W-1:0] rem_s [0:N];
	logic [VAL_W-1:0] res_s [0:N];
	logic [SB_W-1:0]  sb_s  [0:N];

	assign vld_s[0] = vld;
	assign rem_s[0] = val;
	assign res_s[0] = '0;
	assign sb_s[0] = sb;

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic [VAL_W-1:0] BIT = VAL_W'(1) << (2 * (N - 1 - i));
		logic [VAL_W-1:0] trial;
		logic [VAL_W-1:0] rem_d;
		logic [VAL_W-1:0] res_d;

		always_comb begin
			trial = res_s[i] + BIT;
			if (rem_s[i] >= trial) begin
				rem_d = rem_s[i] - trial;
				res_d = (res_s[i] >> 1) + BIT;
			end else begin
				rem_d = rem_s[i];
				res_d = res_s[i] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= rem_d;
				res_s[i+1] <= res_d;
				sb_s[i+1] <= sb_s[i];
			end
		end
	end

	assign root_vld = vld_s[N];
	assign root = res_s[N][N-1:0];
	assign root_sb = sb_s[N];

endmodule

// File: hdl/rounded_rect_aa_pixel_shader_core.sv
// top level: rounded-rectangle panel shader with anti-aliased edges
//
// Pixel items enter on pix (pix_valid/pix_ready) and ARGB items leave on col
// (col_valid/col_ready), one result per pixel, in order. Panel width, height
// and corner radius are written on the cfg channel (index 0, 1, 2; other
// indexes are dropped); cfg_ready is always high and writes take effect on
// the next pixel, so they belong in idle time between frames.
// From acceptance to col_valid the stages are geometry and squaring, forming
// the radicand, the square root (one result bit per stage), then distance,
// band select, weight and color stages.
// Throughput is one pixel per clock unless the output stalls. All stages
// advance together, so when col_ready is low with a result waiting, the
// whole pipeline holds and pix_ready drops; nothing is lost or repeated.
// Reset clears every valid bit and loads a 64 x 32 panel with radius 8.
module rounded_rect_aa_pixel_shader_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pix_valid,
	output logic                    pix_ready,
	input  rrs_pkg::pix_t           pix,
	output logic                    col_valid,
	input  logic                    col_ready,
	output rrs_pkg::col_t           col,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [31:0]             cfg_data
);

	localparam int DW = rrs_pkg::DIM_W;
	localparam int RW = rrs_pkg::RAD_W;
	localparam int QW = rrs_pkg::Q_W;
	localparam int DSW = rrs_pkg::DIST_W;
	localparam int VW = rrs_pkg::SQRT_VAL_W;
	localparam int SBW = $bits(rrs_pkg::side_t);

	logic [DW-1:0] width_q, height_q;
	logic [RW-1:0] radius_q;
	logic adv;

	assign cfg_ready = 1'b1;
	assign adv = !col_valid || col_ready;
	assign pix_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd64;
			height_q <= 11'd32;
			radius_q <= 10'd8;
		end else if (cfg_valid) begin
			case (cfg_index)
				rrs_pkg::REG_WIDTH:  width_q <= cfg_data[DW-1:0];
				rrs_pkg::REG_HEIGHT: height_q <= cfg_data[DW-1:0];
				rrs_pkg::REG_RADIUS: radius_q <= cfg_data[RW-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: panel geometry, q in half-pixels
	logic [DW-1:0] w_sat, h_sat, rad_c;
	logic off_panel;
	logic signed [QW-1:0] dxs, dys, adx, ady, qx_d, qy_d;

	always_comb begin
		w_sat = (width_q > DW'(rrs_pkg::MAX_DIM)) ? DW'(rrs_pkg::MAX_DIM) : width_q;
		h_sat = (height_q > DW'(rrs_pkg::MAX_DIM)) ? DW'(rrs_pkg::MAX_DIM) : height_q;
		off_panel = (w_sat == '0) || (h_sat == '0) || ({1'b0, pix.pixel_x} >= w_sat)
			|| ({1'b0, pix.pixel_y} >= h_sat);
		rad_c = {1'b0, radius_q};
		if (rad_c > (w_sat >> 1)) rad_c = w_sat >> 1;
		if (rad_c > (h_sat >> 1)) rad_c = h_sat >> 1;
		dxs = $signed({2'b0, pix.pixel_x, 1'b1}) - $signed({2'b0, w_sat});
		dys = $signed({2'b0, pix.pixel_y, 1'b1}) - $signed({2'b0, h_sat});
		adx = dxs[QW-1] ? -dxs : dxs;
		ady = dys[QW-1] ? -dys : dys;
		qx_d = adx - ($signed({2'b0, w_sat}) - $signed({1'b0, rad_c, 1'b0}));
		qy_d = ady - ($signed({2'b0, h_sat}) - $signed({1'b0, rad_c, 1'b0}));
	end

	logic vld_s1, kill_s1;
	logic signed [QW-1:0] qx_s1, qy_s1;
	logic [RW-1:0] rad_s1;

	// stage 2: squares of the positive parts
	logic vld_s2;
	logic [rrs_pkg::SQ_W-1:0] sqx_s2, sqy_s2;
	rrs_pkg::side_t side_s2;
	logic [rrs_pkg::AX_W-1:0] ax, ay;

	assign ax = (qx_s1 > 0) ? qx_s1[rrs_pkg::AX_W-1:0] : '0;
	assign ay = (qy_s1 > 0) ? qy_s1[rrs_pkg::AX_W-1:0] : '0;

	// stage 3: radicand in Q.8 squared
	logic vld_s3;
	logic [VW-1:0] val_s3;
	rrs_pkg::side_t side_s3;

	logic root_vld;
	logic [VW/2-1:0] root;
	logic [SBW-1:0] root_sb_raw;
	rrs_pkg::side_t root_sb;

	rrs_isqrt #(.VAL_W(VW), .SB_W(SBW)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld      (vld_s3),
		.val      (val_s3),
		.sb       (side_s3),
		.root_vld (root_vld),
		.root     (root),
		.root_sb  (root_sb_raw)
	);
	assign root_sb = rrs_pkg::side_t'(root_sb_raw);

	// stage 4: signed distance in Q.8
	logic vld_s4, kill_s4;
	logic signed [DSW-1:0] dist_s4, edge_d;

	assign edge_d = (root != '0) ? $signed({3'b0, root})
		: $signed({{(DSW-QW-7){root_sb.mq[QW-1]}}, root_sb.mq, 7'b0});

	// stage 5: band and weight numerator
	logic vld_s5, kill_s5;
	rrs_pkg::band_t band_s5, band_d;
	logic [rrs_pkg::NUM_W-1:0] num_s5, num_d;
	logic signed [DSW-1:0] num_wide;

	always_comb begin
		num_wide = '0;
		if (dist_s4 >= rrs_pkg::HALF_AA) begin
			band_d = rrs_pkg::BAND_NONE;
		end else if (dist_s4 >= -rrs_pkg::HALF_AA) begin
			band_d = rrs_pkg::BAND_OUTER;
			num_wide = rrs_pkg::HALF_AA - dist_s4;
		end else if (dist_s4 >= -rrs_pkg::INNER_BORDER) begin
			band_d = rrs_pkg::BAND_BORDER;
		end else if (dist_s4 >= -rrs_pkg::INNER_FRINGE) begin
			band_d = rrs_pkg::BAND_INNER;
			num_wide = dist_s4 + rrs_pkg::INNER_FRINGE;
		end else begin
			band_d = rrs_pkg::BAND_FILL;
		end
		num_d = num_wide[rrs_pkg::NUM_W-1:0];
	end

	// stage 6: t = round(num * 256 / 307) through a reciprocal multiply
	logic vld_s6, kill_s6;
	rrs_pkg::band_t band_s6;
	logic [rrs_pkg::T_W-1:0] t_s6, t_d;
	logic [32:0] prod;

	always_comb begin
		prod = 33'({num_s5, 8'b0} + rrs_pkg::AA_HALF_ROUND) * 33'(rrs_pkg::RECIP_K);
		t_d = (prod[32:rrs_pkg::RECIP_SH] > rrs_pkg::T_ONE) ? rrs_pkg::T_ONE
			: prod[32:rrs_pkg::RECIP_SH];
	end

	// stage 7: color
	rrs_pkg::col_t col_d;
	logic [16:0] fringe_a;

	always_comb begin
		fringe_a = 17'(rrs_pkg::BDR_A) * 17'(t_s6) + 17'd128;
		col_d = '0;
		case (band_s6)
			rrs_pkg::BAND_OUTER: begin
				if (fringe_a[15:8] >= rrs_pkg::FAINT_ALPHA) begin
					col_d = '{fringe_a[15:8], rrs_pkg::BDR_R, rrs_pkg::BDR_G,
						rrs_pkg::BDR_B};
				end
			end
			rrs_pkg::BAND_BORDER: col_d = '{rrs_pkg::BDR_A, rrs_pkg::BDR_R,
				rrs_pkg::BDR_G, rrs_pkg::BDR_B};
			rrs_pkg::BAND_INNER: col_d = '{
				rrs_pkg::blend(rrs_pkg::BDR_A, rrs_pkg::FILL_A, t_s6),
				rrs_pkg::blend(rrs_pkg::BDR_R, rrs_pkg::FILL_R, t_s6),
				rrs_pkg::blend(rrs_pkg::BDR_G, rrs_pkg::FILL_G, t_s6),
				rrs_pkg::blend(rrs_pkg::BDR_B, rrs_pkg::FILL_B, t_s6)};
			rrs_pkg::BAND_FILL: col_d = '{rrs_pkg::FILL_A, rrs_pkg::FILL_R,
				rrs_pkg::FILL_G, rrs_pkg::FILL_B};
			default: col_d = '0;
		endcase
		if (kill_s6) col_d = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			col_valid <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pix_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= root_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			col_valid <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kill_s1 <= off_panel;
			qx_s1 <= qx_d;
			qy_s1 <= qy_d;
			rad_s1 <= rad_c[RW-1:0];

			sqx_s2 <= ax * ax;
			sqy_s2 <= ay * ay;
			side_s2.kill <= kill_s1;
			side_s2.mq <= (qx_s1 > qy_s1) ? qx_s1 : qy_s1;
			side_s2.rad <= rad_s1;

			val_s3 <= VW'({(rrs_pkg::SQ_W+1)'(sqx_s2) + (rrs_pkg::SQ_W+1)'(sqy_s2), 14'b0});
			side_s3 <= side_s2;

			kill_s4 <= root_sb.kill;
			dist_s4 <= edge_d - $signed({(DSW-RW-8)'(0), root_sb.rad, 8'b0});

			kill_s5 <= kill_s4;
			band_s5 <= band_d;
			num_s5 <= num_d;

			kill_s6 <= kill_s5;
			band_s6 <= band_s5;
			t_s6 <= t_d;

			col <= col_d;
		end
	end

endmodule
